FILE: src/dmavg_pkg.sv
// dmavg_pkg: shared field widths, register indexes, opcodes and the
// command/status structs between the controller and the datapath.
// No dependencies.
`default_nettype none

package dmavg_pkg;

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int WLEN_W     = 7;
    localparam int DEC_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION    = 2'd1;

    // input opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic cfg_wr;
        logic in_load;
        logic fill_cfg;
        logic fill_in;
        logic count_inc;
        logic mem_rd;
        logic sum_sub;
        logic sum_add;
        logic div_start;
        logic div_step;
        logic div_end;
        logic out_load;
        logic out_adv;
    } dmavg_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic op_preload;
        logic adv_due;
        logic div_done;
        logic cfg_hit;
    } dmavg_status_t;

endpackage

`default_nettype wire

FILE: src/dmavg_dp.sv
// dmavg_dp: datapath of the moving average: config registers, sample ring,
// running sum, call counter, bit-serial divider and output word register.
// Depends on dmavg_pkg.
`default_nettype none

module dmavg_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  dmavg_pkg::dmavg_cmd_t                 cmd,
    input  wire  [dmavg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [dmavg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                   in_op,
    input  wire  [dmavg_pkg::VALUE_W-1:0]         in_value,
    output dmavg_pkg::dmavg_status_t              status,
    output logic [dmavg_pkg::VALUE_W-1:0]         out_average,
    output logic                                  out_adv
);

    localparam int VW     = dmavg_pkg::VALUE_W;
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = VW + LEN_W;
    localparam int CMP_W  = (LEN_W > dmavg_pkg::WLEN_W) ? LEN_W : dmavg_pkg::WLEN_W;
    localparam int CNT_W  = $clog2(SUM_W + 1);
    localparam int DEC_W  = dmavg_pkg::DEC_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WINDOW);

    // configuration and filter state
    logic [dmavg_pkg::WLEN_W-1:0] wlen_reg;
    logic [DEC_W-1:0]             dec_reg;
    logic [DEC_W-1:0]             calls_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [VW-1:0]                avg_reg;
    logic [VW-1:0]                fill_val_reg;
    logic [LEN_W-1:0]             fill_cnt_reg;
    logic [IDX_W-1:0]             pos_reg;

    // captured input word
    logic                         op_reg;
    logic [VW-1:0]                value_reg;

    // sample ring
    logic [VW-1:0]                ring [0:MAX_WINDOW-1];
    logic [VW-1:0]                rd_reg;

    // divider
    logic [LEN_W-1:0]             rem_reg;
    logic [SUM_W-1:0]             quo_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             cnt_reg;

    // output word
    logic [VW-1:0]                out_avg_reg;
    logic                         out_adv_reg;

    logic [CMP_W-1:0]             wlen_ext;
    logic [LEN_W-1:0]             len;
    logic [DEC_W:0]               calls_inc;
    logic [DEC_W-1:0]             dec_eff;
    logic [LEN_W-1:0]             pos_ext;
    logic [LEN_W-1:0]             pos_inc;
    logic [VW-1:0]                old_sample;
    logic [VW-1:0]                fill_src;
    logic signed [SUM_W:0]        fill_prod;
    logic [LEN_W:0]               trial;
    logic [LEN_W:0]               trial_diff;
    logic                         trial_ge;
    logic [VW-1:0]                quo_low;

    // effective window length: zero acts as one, clamp to the ring depth
    always_comb begin
        wlen_ext = CMP_W'(wlen_reg);
        if (wlen_reg == '0) begin
            len = LEN_W'(1);
        end else if (wlen_ext > MAX_CMP) begin
            len = LEN_W'(MAX_WINDOW);
        end else begin
            len = LEN_W'(wlen_ext);
        end
    end

    // decimation compare
    assign calls_inc = {1'b0, calls_reg} + (DEC_W + 1)'(1);
    assign dec_eff   = (dec_reg == '0) ? DEC_W'(1) : dec_reg;

    // ring position and fill tracking; entries past the fill count hold the fill value
    assign pos_ext    = LEN_W'(pos_reg);
    assign pos_inc    = pos_ext + LEN_W'(1);
    assign old_sample = (pos_ext < fill_cnt_reg) ? rd_reg : fill_val_reg;

    // fill multiply
    assign fill_src  = cmd.fill_cfg ? avg_reg : value_reg;
    assign fill_prod = $signed(fill_src) * $signed({1'b0, len});

    // divider step: restoring, one quotient bit a cycle
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge   = (trial >= {1'b0, len});
    assign trial_diff = trial - {1'b0, len};
    assign quo_low    = quo_reg[VW-1:0];

    // config and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg     <= dmavg_pkg::WLEN_W'(1);
            dec_reg      <= DEC_W'(1);
            calls_reg    <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            fill_val_reg <= '0;
            fill_cnt_reg <= '0;
            pos_reg      <= '0;
        end else begin
            if (cmd.cfg_wr) begin
                if (cfg_index == dmavg_pkg::REG_WINDOW_LENGTH) begin
                    wlen_reg <= cfg_data[dmavg_pkg::WLEN_W-1:0];
                end else if (cfg_index == dmavg_pkg::REG_DECIMATION) begin
                    dec_reg <= cfg_data[DEC_W-1:0];
                end
            end
            if (cmd.fill_cfg || cmd.fill_in) begin
                sum_reg      <= fill_prod[SUM_W-1:0];
                avg_reg      <= fill_src;
                fill_val_reg <= fill_src;
                fill_cnt_reg <= '0;
                calls_reg    <= '0;
                pos_reg      <= '0;
            end
            if (cmd.count_inc) begin
                calls_reg <= calls_inc[DEC_W-1:0];
            end
            if (cmd.sum_sub) begin
                sum_reg   <= sum_reg - {{(SUM_W-VW){old_sample[VW-1]}}, old_sample};
                calls_reg <= '0;
                if (pos_ext == fill_cnt_reg) begin
                    fill_cnt_reg <= fill_cnt_reg + LEN_W'(1);
                end
                pos_reg <= (pos_inc == len) ? '0 : pos_inc[IDX_W-1:0];
            end
            if (cmd.sum_add) begin
                sum_reg <= sum_reg + {{(SUM_W-VW){value_reg[VW-1]}}, value_reg};
            end
            if (cmd.div_end) begin
                avg_reg <= neg_reg ? (VW'(0) - quo_low) : quo_low;
            end
        end
    end

    // input word capture
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg    <= in_op;
            value_reg <= in_value;
        end
    end

    // ring write and registered read
    always_ff @(posedge aclk) begin
        if (cmd.sum_sub) begin
            ring[pos_reg] <= value_reg;
        end
        if (cmd.mem_rd) begin
            rd_reg <= ring[pos_reg];
        end
    end

    // divider registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.div_start) begin
            cnt_reg <= CNT_W'(SUM_W);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg <= trial_ge ? trial_diff[LEN_W-1:0] : trial[LEN_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_avg_reg <= avg_reg;
            out_adv_reg <= cmd.out_adv;
        end
    end

    assign out_average = out_avg_reg;
    assign out_adv     = out_adv_reg;

    // status
    always_comb begin
        status.op_preload = (op_reg == dmavg_pkg::OP_PRELOAD);
        status.adv_due    = (calls_inc >= {1'b0, dec_eff});
        status.div_done   = (cnt_reg == '0);
        status.cfg_hit    = (cfg_index == dmavg_pkg::REG_WINDOW_LENGTH) ||
                            (cfg_index == dmavg_pkg::REG_DECIMATION);
    end

endmodule

`default_nettype wire

FILE: src/dmavg_ctrl.sv
// dmavg_ctrl: sequencing state machine for the moving average, handshakes
// on all three channels and the output valid flag.
// Depends on dmavg_pkg.
`default_nettype none

module dmavg_ctrl (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  dmavg_pkg::dmavg_status_t       status,
    output dmavg_pkg::dmavg_cmd_t          cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EVAL     = 4'd1;
    localparam logic [3:0] S_CFG_FILL = 4'd2;
    localparam logic [3:0] S_PRELOAD  = 4'd3;
    localparam logic [3:0] S_SUB      = 4'd4;
    localparam logic [3:0] S_ADD      = 4'd5;
    localparam logic [3:0] S_DIV_INIT = 4'd6;
    localparam logic [3:0] S_DIV      = 4'd7;
    localparam logic [3:0] S_DIV_END  = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       adv_reg;
    logic       adv_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       cfg_accept;
    logic       in_accept;

    // config takes precedence when both arrive in the same idle cycle
    assign cfg_ready  = (state_reg == S_IDLE);
    assign s_tready   = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = s_tvalid && s_tready;
    assign m_tvalid   = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        adv_next     = adv_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        case (state_reg)
            S_IDLE: begin
                if (cfg_accept) begin
                    cmd.cfg_wr = 1'b1;
                    if (status.cfg_hit) begin
                        state_next = S_CFG_FILL;
                    end
                end else if (in_accept) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                if (status.op_preload) begin
                    adv_next   = 1'b0;
                    state_next = S_PRELOAD;
                end else if (status.adv_due) begin
                    cmd.mem_rd = 1'b1;
                    adv_next   = 1'b1;
                    state_next = S_SUB;
                end else begin
                    cmd.count_inc = 1'b1;
                    adv_next      = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_CFG_FILL: begin
                cmd.fill_cfg = 1'b1;
                state_next   = S_IDLE;
            end
            S_PRELOAD: begin
                cmd.fill_in = 1'b1;
                state_next  = S_OUT;
            end
            S_SUB: begin
                cmd.sum_sub = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD: begin
                cmd.sum_add = 1'b1;
                state_next  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (status.div_done) begin
                    state_next = S_DIV_END;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            S_DIV_END: begin
                cmd.div_end = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    cmd.out_adv  = adv_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            adv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            adv_reg     <= adv_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/decimated_moving_average.sv
// decimated_moving_average: top level, joins the controller and datapath.
// Depends on dmavg_pkg, dmavg_ctrl and dmavg_dp.
//
// Usage: samples arrive on the s_ stream (s_tdata = value, s_tuser = op:
// sample or preload). Every input word gives exactly one result word on the
// m_ stream (m_tdata = average, m_tuser = window advanced). Registers are
// written on the cfg_ channel (index 0 window length, index 1 decimation);
// a write to either refills the window with the current average. Each input
// word is worked on alone: a sample that does not advance the window goes from
// evaluation to the output state, a preload through the preload fill first;
// a sample that advances the window passes subtract, add, divider start, the
// restoring divider, which produces one quotient bit of the SUM_W-bit running
// sum per cycle, and divider end. The result sits in an output register, so
// the next word is accepted while it waits; a stalled m_tready only holds the
// block once a second result is ready. Reset clears all filter state: the
// window reads as zeros through a fill counter, so no clearing pass is needed
// and the block is ready the cycle after reset.
`default_nettype none

module decimated_moving_average #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // input stream
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    input  wire  [31:0]                           s_tdata,   // [31:0] value
    input  wire                                   s_tuser,   // [0] op
    // result stream
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    output logic [31:0]                           m_tdata,   // [31:0] average
    output logic                                  m_tuser,   // [0] window_advanced
    // configuration writes
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire  [dmavg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [dmavg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    dmavg_pkg::dmavg_cmd_t    cmd;
    dmavg_pkg::dmavg_status_t status;

    dmavg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    dmavg_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_op       (s_tuser),
        .in_value    (s_tdata),
        .status      (status),
        .out_average (m_tdata),
        .out_adv     (m_tuser)
    );

    // an accepted word keeps the block busy in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !cfg_ready)
        else $error("input accepted while a word is still in progress");

    // a register write that hits a real register triggers the refill cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && status.cfg_hit |=> cmd.fill_cfg)
        else $error("config write did not refill the window");

    // a new result only appears after the block has been busy with a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result produced without a word in progress");

    // divider steps only while its count runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !status.div_done)
        else $error("divider stepped past its last bit");

endmodule

`default_nettype wire
